/* sv/tss_pkg.sv */
// ----------------------------------------------------------------------------
// tss_pkg
// Shared constants, types and the divisor function for the series sine block.
// ----------------------------------------------------------------------------
package tss_pkg;

  // Series cap and number format.
  localparam int MAX_TERMS = 24;
  localparam int FRAC_BITS = 28;

  // Field widths fixed by the interface.
  localparam int ANGLE_W = 32;
  localparam int SINE_W  = 32;
  localparam int TERMS_W = 5;
  localparam int THR_W   = 29;
  localparam logic [THR_W-1:0] THR_RESET = 29'd27;

  // Configuration port.
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_IDX_THRESHOLD = 1'b0;

  // Term magnitude holds values up to 2^60; the running sum is 64-bit signed.
  localparam int TERM_W = 61;
  localparam int SUM_W  = 64;
  localparam logic [TERM_W-1:0] TERM_MAX = {1'b1, {(TERM_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] SUM_MAX = 64'sh4000_0000_0000_0000;
  localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_MAX;
  localparam logic signed [SUM_W-1:0] SINE_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [SUM_W-1:0] SINE_LO = -64'sh0000_0000_8000_0000;

  // Square of the angle magnitude, scaled back by the fraction bits.
  localparam int SQ_W = 2 * ANGLE_W;
  localparam int X2_W = SQ_W - FRAC_BITS;

  // Multiplier built from 32 x 32 partial products.
  localparam int CHUNK_LG = 5;
  localparam int CHUNK_W  = 1 << CHUNK_LG;
  localparam int T_CH     = (TERM_W + CHUNK_W - 1) / CHUNK_W;
  localparam int X_CH     = (X2_W + CHUNK_W - 1) / CHUNK_W;
  localparam int PROD_W   = CHUNK_W * (T_CH + X_CH);
  localparam int TI_W     = (T_CH > 1) ? $clog2(T_CH) : 1;
  localparam int XI_W     = (X_CH > 1) ? $clog2(X_CH) : 1;
  localparam int SH_W     = (T_CH + X_CH > 2) ? $clog2(T_CH + X_CH - 1) : 1;

  // Term index and divisor (2k+2)(2k+3).
  localparam int K_W   = $clog2(MAX_TERMS + 1);
  localparam int DIV_W = $clog2(2 * MAX_TERMS * (2 * MAX_TERMS + 1) + 1);

  // Radix-4 restoring divider: two quotient bits per cycle.
  localparam int DIV_N = (TERM_W + 1) / 2;
  localparam int QW    = 2 * DIV_N;
  localparam int DC_W  = $clog2(DIV_N + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_TEST,
    ST_MUL,
    ST_DIV,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic load;
    logic square;
    logic add_term;
    logic div_start;
    logic next_term;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic k_cap;
    logic t_small;
    logic mul_busy;
    logic div_busy;
  } dp_status_t;

  function automatic logic [DIV_W-1:0] term_divisor(input logic [K_W-1:0] k);
    int kk;
    kk = int'(k);
    return DIV_W'((2 * kk + 2) * (2 * kk + 3));
  endfunction

endpackage

/* sv/tss_ctrl.sv */
// ----------------------------------------------------------------------------
// tss_ctrl
// Sequencer for the series evaluation and the output valid flag.
// ----------------------------------------------------------------------------
module tss_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  tss_pkg::dp_status_t  status_i,
  output tss_pkg::dp_cmd_t     cmd_o
);
  import tss_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q & out_stall_i;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = ST_TEST;
      end
      ST_TEST: begin
        if (status_i.k_cap || status_i.t_small) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.add_term = 1'b1;
          state_d        = ST_MUL;
        end
      end
      ST_MUL: begin
        if (!status_i.mul_busy) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!status_i.div_busy) begin
          cmd_o.next_term = 1'b1;
          state_d         = ST_TEST;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* sv/tss_dpath.sv */
// ----------------------------------------------------------------------------
// tss_dpath
// Term, square and sum registers, chunked multiplier and radix-4 divider.
// ----------------------------------------------------------------------------
module tss_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic signed [tss_pkg::ANGLE_W-1:0]  angle_i,
  input  logic [tss_pkg::THR_W-1:0]           thr_i,
  input  tss_pkg::dp_cmd_t                    cmd_i,
  output tss_pkg::dp_status_t                 status_o,
  output logic signed [tss_pkg::SINE_W-1:0]   sine_o,
  output logic [tss_pkg::TERMS_W-1:0]         terms_used_o,
  output logic                                limit_hit_o
);
  import tss_pkg::*;

  // Operand and accumulation state.
  logic [ANGLE_W-1:0]          mag_q;
  logic                        neg_q;
  logic [X2_W-1:0]             x2_q;
  logic [TERM_W-1:0]           t_q;
  logic [K_W-1:0]              k_q;
  logic signed [SUM_W-1:0]     sum_q;

  // Multiplier.
  logic                        mul_act_q, pp_v_q;
  logic [TI_W-1:0]             ti_q;
  logic [XI_W-1:0]             xi_q;
  logic [2*CHUNK_W-1:0]        pp_q;
  logic [SH_W-1:0]             pp_sh_q;
  logic [PROD_W-1:0]           acc_q;
  logic [T_CH*CHUNK_W-1:0]     t_pad;
  logic [X_CH*CHUNK_W-1:0]     x_pad;
  logic                        mul_last;

  // Divider.
  logic [DC_W-1:0]             div_cnt_q;
  logic [DIV_W-1:0]            div_q;
  logic [DIV_W-1:0]            rem_q, rem_d;
  logic [QW-1:0]               quo_q, quo_d;

  // Output payload.
  logic signed [SINE_W-1:0]    sine_q;
  logic [TERMS_W-1:0]          terms_q;
  logic                        limit_q;

  logic [ANGLE_W-1:0]          mag_in;
  logic [SQ_W-1:0]             mag_sq;
  logic [PROD_W-FRAC_BITS-1:0] prod_shift;
  logic [TERM_W-1:0]           prod_term;
  logic signed [SUM_W-1:0]     t_ext, sum_add, sum_clamp;
  logic signed [SINE_W-1:0]    sine_sat;

  assign mag_in = angle_i[ANGLE_W-1] ? (~angle_i + 1'b1) : angle_i;
  assign mag_sq = SQ_W'(mag_q) * SQ_W'(mag_q);

  assign t_pad    = (T_CH * CHUNK_W)'(t_q);
  assign x_pad    = (X_CH * CHUNK_W)'(x2_q);
  assign mul_last = (ti_q == TI_W'(T_CH - 1)) && (xi_q == XI_W'(X_CH - 1));

  // Product scaled back by the fraction bits and clamped to 2^60.
  assign prod_shift = acc_q[PROD_W-1:FRAC_BITS];
  assign prod_term  = (prod_shift > (PROD_W - FRAC_BITS)'(TERM_MAX)) ?
                      TERM_MAX : prod_shift[TERM_W-1:0];

  // Signed term add with clamping to the intermediate range.
  assign t_ext   = $signed(SUM_W'(t_q));
  assign sum_add = (neg_q ^ k_q[0]) ? (sum_q - t_ext) : (sum_q + t_ext);
  always_comb begin
    if (sum_add > SUM_MAX) begin
      sum_clamp = SUM_MAX;
    end else if (sum_add < SUM_MIN) begin
      sum_clamp = SUM_MIN;
    end else begin
      sum_clamp = sum_add;
    end
  end

  always_comb begin
    if (sum_q > SINE_HI) begin
      sine_sat = SINE_HI[SINE_W-1:0];
    end else if (sum_q < SINE_LO) begin
      sine_sat = SINE_LO[SINE_W-1:0];
    end else begin
      sine_sat = sum_q[SINE_W-1:0];
    end
  end

  // Two restoring division steps per cycle.
  always_comb begin
    logic [DIV_W:0] r1, r2;
    logic           ge1, ge2;
    r1  = {rem_q, quo_q[QW-1]};
    ge1 = (r1 >= {1'b0, div_q});
    if (ge1) begin
      r1 = r1 - {1'b0, div_q};
    end
    r2  = {r1[DIV_W-1:0], quo_q[QW-2]};
    ge2 = (r2 >= {1'b0, div_q});
    if (ge2) begin
      r2 = r2 - {1'b0, div_q};
    end
    rem_d = r2[DIV_W-1:0];
    quo_d = {quo_q[QW-3:0], ge1, ge2};
  end

  // Control registers of the multiplier and divider.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_act_q <= 1'b0;
      pp_v_q    <= 1'b0;
      ti_q      <= '0;
      xi_q      <= '0;
      div_cnt_q <= '0;
    end else begin
      if (cmd_i.add_term) begin
        mul_act_q <= 1'b1;
        pp_v_q    <= 1'b0;
        ti_q      <= '0;
        xi_q      <= '0;
      end else begin
        pp_v_q <= mul_act_q;
        if (mul_act_q) begin
          if (mul_last) begin
            mul_act_q <= 1'b0;
          end
          if (xi_q == XI_W'(X_CH - 1)) begin
            xi_q <= '0;
            ti_q <= ti_q + 1'b1;
          end else begin
            xi_q <= xi_q + 1'b1;
          end
        end
      end
      if (cmd_i.div_start) begin
        div_cnt_q <= DC_W'(DIV_N);
      end else if (div_cnt_q != '0) begin
        div_cnt_q <= div_cnt_q - 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q <= mag_in;
      neg_q <= angle_i[ANGLE_W-1];
    end
    if (cmd_i.square) begin
      x2_q  <= mag_sq[SQ_W-1:FRAC_BITS];
      t_q   <= TERM_W'(mag_q);
      k_q   <= '0;
      sum_q <= '0;
    end
    if (cmd_i.add_term) begin
      sum_q <= sum_clamp;
      acc_q <= '0;
    end else if (pp_v_q) begin
      acc_q <= acc_q + (PROD_W'(pp_q) << {pp_sh_q, CHUNK_LG'(0)});
    end
    if (mul_act_q) begin
      pp_q    <= (2*CHUNK_W)'(t_pad[ti_q*CHUNK_W +: CHUNK_W]) *
                 (2*CHUNK_W)'(x_pad[xi_q*CHUNK_W +: CHUNK_W]);
      pp_sh_q <= SH_W'(ti_q) + SH_W'(xi_q);
    end
    if (cmd_i.div_start) begin
      div_q <= term_divisor(k_q);
      rem_q <= '0;
      quo_q <= QW'(prod_term);
    end else if (div_cnt_q != '0) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
    if (cmd_i.next_term) begin
      t_q <= quo_q[TERM_W-1:0];
      k_q <= k_q + 1'b1;
    end
    if (cmd_i.emit) begin
      sine_q  <= sine_sat;
      terms_q <= TERMS_W'(k_q);
      limit_q <= status_o.k_cap;
    end
  end

  assign status_o.k_cap    = (k_q >= K_W'(MAX_TERMS));
  assign status_o.t_small  = (t_q <= TERM_W'(thr_i));
  assign status_o.mul_busy = mul_act_q | pp_v_q;
  assign status_o.div_busy = (div_cnt_q != '0);

  assign sine_o       = sine_q;
  assign terms_used_o = terms_q;
  assign limit_hit_o  = limit_q;

endmodule

/* sv/taylor_sine_series.sv */
// ----------------------------------------------------------------------------
// taylor_sine_series
// Sine of a Q4.28 angle by summing its Maclaurin series in fixed point.
// ----------------------------------------------------------------------------
// The input channel carries one angle in radians per transfer; the output
// channel returns the saturated Q4.28 sum, the number of terms added and a
// flag set when the term cap was reached before the stop level. Both use
// valid and stall; a transfer happens on an edge with valid high, stall low.
// The transfer registers the angle's magnitude and the next cycle forms its
// square. Each term is then tested and added, passes the multiplier (four
// 32 x 32 partial products, the last accumulation and the hand-over) and
// the two-bits-per-cycle divider (31 steps and the hand-back). With the cap
// an angle takes at most 24 terms; in_stall_o is high until its result
// reaches the output register, and the next angle can be taken in the cycle
// after. If the receiver stalls, the result holds in the output register
// and a second result waits in the datapath until it frees.
// Reset clears the sequencer and the output valid flag and sets the stop
// level to 27 (about 1e-7), written over the APB-style port at address 0.
// ----------------------------------------------------------------------------
module taylor_sine_series (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Angle channel.
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [tss_pkg::ANGLE_W-1:0]  angle_i,
  // Result channel.
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [tss_pkg::SINE_W-1:0]   sine_o,
  output logic [tss_pkg::TERMS_W-1:0]         terms_used_o,
  output logic                                limit_hit_o,
  // Configuration port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tss_pkg::APB_AW-1:0]          paddr,
  input  logic [tss_pkg::APB_DW-1:0]          pwdata,
  output logic [tss_pkg::APB_DW-1:0]          prdata,
  output logic                                pready
);
  import tss_pkg::*;

  logic [THR_W-1:0] thr_q;
  logic             reg_sel;
  dp_cmd_t          cmd;
  dp_status_t       status;

  // Registers sit on word addresses; only the stop level exists.
  assign reg_sel = (paddr[APB_AW-1] == REG_IDX_THRESHOLD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      thr_q <= pwdata[THR_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = reg_sel ? APB_DW'(thr_q) : '0;

  // The sequencer steps the datapath through test, multiply and divide for
  // each term and hands the result to the output register.
  tss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tss_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .angle_i      (angle_i),
    .thr_i        (thr_q),
    .cmd_i        (cmd),
    .status_o     (status),
    .sine_o       (sine_o),
    .terms_used_o (terms_used_o),
    .limit_hit_o  (limit_hit_o)
  );

endmodule
